// ----- hdl/frt_pkg.sv -----
// ----------------------------------------------------------------------------
// frt_pkg
// shared types and constants of the flow registry with tombstone ring
// ----------------------------------------------------------------------------
`default_nettype none

package frt_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int TOMBSTONES_DEF    = 64;
  localparam int KEY_BITS_DEF      = 64;
  localparam int WID_BITS_DEF      = 8;

  localparam logic [31:0] GRACE_RESET = 32'd10000;

  typedef enum logic [2:0] {
    CMD_REGISTER      = 3'd0,
    CMD_UNREGISTER    = 3'd1,
    CMD_RETIRE        = 3'd2,
    CMD_MARK_DRAINING = 3'd3,
    CMD_RETIRE_DRAIN  = 3'd4,
    CMD_LOOKUP        = 3'd5,
    CMD_STILL_OWNS    = 3'd6,
    CMD_DROP_ALL      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_DR_RD,
    S_DR_CHK,
    S_SCAN,
    S_POP,
    S_GEN,
    S_EXEC,
    S_EVICT,
    S_APPEND,
    S_RESP
  } state_t;

  // where a drain pass continues when the ring is empty or its front is not expired
  typedef enum logic {
    RET_GEN,
    RET_PUSH
  } ret_t;

  // what a table scan is looking up
  typedef enum logic {
    SC_CMD,
    SC_POP
  } scan_t;

endpackage

`default_nettype wire

// ----- hdl/frt_ifs.sv -----
// ----------------------------------------------------------------------------
// frt channel interfaces
// request, response and grace configuration channels, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface frt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [63:0] tuple_key;
  logic [63:0] generation;
  logic [7:0]  worker_id;
  logic [7:0]  protocol;
  logic        graceful;
  logic [63:0] now_ms;

  modport source (output valid, command, tuple_key, generation, worker_id, protocol,
                  graceful, now_ms, input ready);
  modport sink (input valid, command, tuple_key, generation, worker_id, protocol,
                graceful, now_ms, output ready);
endinterface

interface frt_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [1:0]  status;
  logic [63:0] found_generation;
  logic [7:0]  found_wid;
  logic        tomb_evicted;

  modport source (output valid, ok, status, found_generation, found_wid, tomb_evicted,
                  input ready);
  modport sink (input valid, ok, status, found_generation, found_wid, tomb_evicted,
                output ready);
endinterface

interface frt_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] grace_ms;

  modport source (output valid, grace_ms, input ready);
  modport sink (input valid, grace_ms, output ready);
endinterface

`default_nettype wire

// ----- hdl/flow_registry_with_tombstone_ring.sv -----
// ----------------------------------------------------------------------------
// flow_registry_with_tombstone_ring
// flow table in one synchronous memory with valid flops, tombstone records
// in a second memory used as a deadline ordered ring
// ----------------------------------------------------------------------------
//  channel | dir | beat carries
//  req     | in  | command, tuple_key, generation, worker_id, protocol, graceful, now_ms
//  rsp     | out | ok, status, found_generation, found_wid, tomb_evicted
//  cfg     | in  | grace_ms (always ready)
//
//  one item at a time; a key search reads the table memory one entry per cycle
//  and stops early on a hit; register: one search per popped record plus one;
//  graceful retire: one search plus one per popped or evicted record; drop all:
//  no search
//  sync reset clears valid flops, ring pointers and the generation counter
//  a stalled response sits in the output register while the next beat is taken
`default_nettype none

module flow_registry_with_tombstone_ring
  import frt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int TOMBSTONES    = TOMBSTONES_DEF,
  parameter int KEY_BITS      = KEY_BITS_DEF,
  parameter int WID_BITS      = WID_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  frt_req_if.sink   req,
  frt_rsp_if.source rsp,
  frt_cfg_if.sink   cfg
);

  localparam int IDXW  = $clog2(TABLE_ENTRIES);
  localparam int RIDXW = $clog2(TOMBSTONES);
  localparam int RCNTW = $clog2(TOMBSTONES + 1);
  localparam int WIDS  = (WID_BITS < 8) ? WID_BITS : 8;

  // table word layout
  localparam int E_KEY   = 0;
  localparam int E_GEN   = KEY_BITS;
  localparam int E_EXP   = KEY_BITS + 64;
  localparam int E_DET   = KEY_BITS + 128;
  localparam int E_DRN   = E_DET + 1;
  localparam int E_WID   = E_DET + 2;
  localparam int E_PROTO = E_WID + WIDS;
  localparam int E_W     = E_PROTO + 8;

  // ring word layout
  localparam int R_GEN = KEY_BITS;
  localparam int R_EXP = KEY_BITS + 64;
  localparam int R_W   = KEY_BITS + 128;

  state_t state, state_next;

  logic [31:0]         grace;
  cmd_t                cmd;
  logic [KEY_BITS-1:0] key;
  logic [63:0]         gen_in;
  logic [WIDS-1:0]     wid_in;
  logic [7:0]          proto_in;
  logic                graceful;
  logic [63:0]         now;
  logic [63:0]         expiry;
  logic [63:0]         next_gen;
  logic [63:0]         gen_inc;

  logic [TABLE_ENTRIES-1:0] valid;
  logic [RIDXW-1:0]         head;
  logic [RCNTW-1:0]         count;
  logic [RCNTW:0]           slot_sum;
  logic [RIDXW-1:0]         slot;
  ret_t                     drain_ret;
  scan_t                    scan_pur;
  logic                     evicting;

  // table memory
  logic [E_W-1:0]  ent_mem [TABLE_ENTRIES];
  logic [E_W-1:0]  ent_rd;
  logic            ent_we;
  logic [IDXW-1:0] ent_waddr;
  logic [E_W-1:0]  ent_wdata;

  // ring memory
  logic [R_W-1:0]   ring_mem [TOMBSTONES];
  logic [R_W-1:0]   ring_rd;
  logic             ring_we;

  // scan
  logic [IDXW:0]       sidx;
  logic                p_vld;
  logic [IDXW-1:0]     p_idx;
  logic                hit;
  logic [IDXW-1:0]     hit_idx;
  logic [E_W-1:0]      hit_word;
  logic                free_found;
  logic [IDXW-1:0]     free_idx;
  logic [KEY_BITS-1:0] skey;
  logic                scan_hit;
  logic                scan_done;
  logic                scan_start;

  // decoded hit entry
  logic [63:0]     h_gen;
  logic [63:0]     h_exp;
  logic            h_det;
  logic            h_drn;
  logic [WIDS-1:0] h_wid;
  logic            routable;
  logic            match;

  // exec decisions
  logic        e_ok;
  status_t     e_st;
  logic [63:0] e_gen;
  logic [7:0]  e_wid;
  logic        e_push;
  logic        v_we;
  logic        v_val;
  logic [IDXW-1:0] v_idx;

  logic        ring_exp_due;

  // results
  logic        res_ok;
  status_t     res_status;
  logic [63:0] res_gen;
  logic [7:0]  res_wid;
  logic        res_ev;

  logic        o_valid;
  logic        o_ok;
  logic [1:0]  o_status;
  logic [63:0] o_gen;
  logic [7:0]  o_wid;
  logic        o_ev;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid            = o_valid;
  assign rsp.ok               = o_ok;
  assign rsp.status           = o_status;
  assign rsp.found_generation = o_gen;
  assign rsp.found_wid        = o_wid;
  assign rsp.tomb_evicted     = o_ev;

  assign skey      = (scan_pur == SC_POP) ? ring_rd[KEY_BITS-1:0] : key;
  assign scan_hit  = p_vld && valid[p_idx] && (ent_rd[E_KEY +: KEY_BITS] == skey);
  assign scan_done = scan_hit || (p_vld && (p_idx == IDXW'(TABLE_ENTRIES - 1)));
  assign scan_start = (state_next == S_SCAN) && (state != S_SCAN);

  assign h_gen    = hit_word[E_GEN +: 64];
  assign h_exp    = hit_word[E_EXP +: 64];
  assign h_det    = hit_word[E_DET];
  assign h_drn    = hit_word[E_DRN];
  assign h_wid    = hit_word[E_WID +: WIDS];
  assign routable = !h_det || (now < h_exp);
  assign match    = hit && (h_gen == gen_in);

  assign ring_exp_due = (now >= ring_rd[R_EXP +: 64]);
  assign gen_inc      = next_gen + 64'd1;

  assign slot_sum = (RCNTW + 1)'(head) + (RCNTW + 1)'(count);
  assign slot     = (slot_sum >= (RCNTW + 1)'(TOMBSTONES))
                    ? RIDXW'(slot_sum - (RCNTW + 1)'(TOMBSTONES)) : RIDXW'(slot_sum);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_START;
      end
      S_START: begin
        if (cmd == CMD_REGISTER) state_next = S_DR_RD;
        else if (cmd == CMD_DROP_ALL) state_next = S_RESP;
        else state_next = S_SCAN;
      end
      S_DR_RD: begin
        if (count == '0) state_next = (drain_ret == RET_GEN) ? S_GEN : S_EVICT;
        else state_next = S_DR_CHK;
      end
      S_DR_CHK: begin
        if (evicting || ring_exp_due) state_next = S_SCAN;
        else state_next = (drain_ret == RET_GEN) ? S_GEN : S_EVICT;
      end
      S_SCAN: begin
        if (scan_done) state_next = (scan_pur == SC_POP) ? S_POP : S_EXEC;
      end
      S_POP: begin
        state_next = evicting ? S_APPEND : S_DR_RD;
      end
      S_GEN: state_next = S_SCAN;
      S_EXEC: begin
        state_next = e_push ? S_DR_RD : S_RESP;
      end
      S_EVICT: begin
        state_next = (count == RCNTW'(TOMBSTONES)) ? S_DR_RD : S_APPEND;
      end
      S_APPEND: state_next = S_RESP;
      S_RESP: begin
        if (!o_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the current state: table writes, valid flop updates, results
  always_comb begin
    e_ok      = 1'b0;
    e_st      = ST_DONE;
    e_gen     = '0;
    e_wid     = '0;
    e_push    = 1'b0;
    ent_we    = 1'b0;
    ent_waddr = hit_idx;
    ent_wdata = hit_word;
    v_we      = 1'b0;
    v_val     = 1'b0;
    v_idx     = hit_idx;
    ring_we   = (state == S_APPEND);
    if (state == S_EXEC) begin
      case (cmd)
        CMD_REGISTER: begin
          if (hit && !h_det) begin
            e_st = ST_REFUSED;
          end else if (!hit && !free_found) begin
            e_st = ST_FULL;
          end else begin
            ent_waddr = hit ? hit_idx : free_idx;
            ent_wdata = {proto_in, wid_in, 1'b0, 1'b0, 64'd0, next_gen, key};
            ent_we    = 1'b1;
            v_we      = 1'b1;
            v_val     = 1'b1;
            v_idx     = ent_waddr;
            e_ok      = 1'b1;
            e_gen     = next_gen;
          end
        end
        CMD_UNREGISTER, CMD_RETIRE, CMD_MARK_DRAINING: begin
          if (!match) begin
            e_st = ST_NOMATCH;
          end else if (cmd == CMD_MARK_DRAINING) begin
            ent_wdata[E_DRN] = 1'b1;
            ent_we = 1'b1;
          end else if (cmd == CMD_UNREGISTER || !graceful) begin
            v_we = 1'b1;
          end else begin
            ent_wdata[E_DET]       = 1'b1;
            ent_wdata[E_EXP +: 64] = expiry;
            ent_we = 1'b1;
            e_push = 1'b1;
          end
        end
        CMD_RETIRE_DRAIN: begin
          if (!match || !h_drn) begin
            e_st = ST_NOMATCH;
          end else if (graceful) begin
            ent_wdata[E_DRN]       = 1'b0;
            ent_wdata[E_DET]       = 1'b1;
            ent_wdata[E_EXP +: 64] = expiry;
            ent_we = 1'b1;
            e_push = 1'b1;
          end else begin
            v_we = 1'b1;
          end
        end
        CMD_LOOKUP: begin
          if (!hit || !routable) begin
            e_st = ST_NOMATCH;
          end else begin
            e_ok  = 1'b1;
            e_gen = h_gen;
            e_wid = 8'(h_wid);
          end
        end
        CMD_STILL_OWNS: begin
          if (hit && routable && h_gen == gen_in && h_wid == wid_in) e_ok = 1'b1;
          else e_st = ST_NOMATCH;
        end
        default: begin
        end
      endcase
    end else if (state == S_POP) begin
      // a leaving record erases only a detached entry of its own generation
      v_we = hit && h_det && (h_gen == ring_rd[R_GEN +: 64]);
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rd <= ent_mem[sidx[IDXW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[slot] <= {expiry, gen_in, key};
    ring_rd <= ring_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      grace    <= GRACE_RESET;
      next_gen <= '0;
      valid    <= '0;
      head     <= '0;
      count    <= '0;
      o_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) grace <= cfg.grace_ms;
      if (state == S_GEN) next_gen <= (gen_inc == 64'd0) ? 64'd1 : gen_inc;
      if (state == S_START && cmd == CMD_DROP_ALL) begin
        valid <= '0;
        head  <= '0;
        count <= '0;
      end else begin
        if (v_we) valid[v_idx] <= v_val;
        if (state == S_POP) begin
          head  <= (head == RIDXW'(TOMBSTONES - 1)) ? '0 : head + 1'b1;
          count <= count - 1'b1;
        end else if (state == S_APPEND) begin
          count <= count + 1'b1;
        end
      end
      if (state == S_RESP && (!o_valid || rsp.ready)) o_valid <= 1'b1;
      else if (rsp.ready) o_valid <= 1'b0;
    end
  end

  // item fields, sequencing context and results
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cmd      <= cmd_t'(req.command);
      key      <= req.tuple_key[KEY_BITS-1:0];
      gen_in   <= req.generation;
      wid_in   <= req.worker_id[WIDS-1:0];
      proto_in <= req.protocol;
      graceful <= req.graceful;
      now      <= req.now_ms;
      expiry   <= req.now_ms + {32'd0, grace};
      evicting <= 1'b0;
    end
    if (state == S_START) begin
      drain_ret  <= RET_GEN;
      res_ok     <= 1'b0;
      res_status <= ST_DONE;
      res_gen    <= '0;
      res_wid    <= '0;
      res_ev     <= 1'b0;
    end
    if (state == S_EXEC) begin
      drain_ret  <= RET_PUSH;
      res_ok     <= e_ok;
      res_status <= e_st;
      res_gen    <= e_gen;
      res_wid    <= e_wid;
    end
    if (state == S_EVICT && count == RCNTW'(TOMBSTONES)) begin
      evicting <= 1'b1;
      res_ev   <= 1'b1;
    end
    if (state == S_START || state == S_GEN) scan_pur <= SC_CMD;
    if (state == S_DR_CHK) scan_pur <= SC_POP;
    if (state == S_RESP && (!o_valid || rsp.ready)) begin
      o_ok     <= res_ok;
      o_status <= res_status;
      o_gen    <= res_gen;
      o_wid    <= res_wid;
      o_ev     <= res_ev;
    end
  end

  // table scan: the read is issued in the cycle before its compare
  always_ff @(posedge clk) begin
    if (scan_start) begin
      sidx       <= '0;
      p_vld      <= 1'b0;
      free_found <= 1'b0;
    end else if (state == S_SCAN) begin
      sidx  <= sidx + 1'b1;
      p_vld <= (sidx < (IDXW + 1)'(TABLE_ENTRIES)) && !scan_done;
      p_idx <= sidx[IDXW-1:0];
      if (p_vld && !valid[p_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= p_idx;
      end
      if (scan_done) hit <= scan_hit;
      if (scan_hit) begin
        hit_idx  <= p_idx;
        hit_word <= ent_rd;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/frt_checker.sv -----
// ----------------------------------------------------------------------------
// frt_checker
// port level checks of the flow registry, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module frt_checker
  import frt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_ok,
  input logic [1:0]  rsp_status,
  input logic [63:0] rsp_found_generation,
  input logic [7:0]  rsp_found_wid,
  input logic        rsp_tomb_evicted
);

  // a stalled beat keeps its ok, status and generation
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_ok)
      && $stable(rsp_found_generation))
    else $error("response changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ok |-> rsp_status == ST_DONE && !rsp_tomb_evicted)
    else $error("ok beat with failure status or eviction");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_DONE |-> rsp_found_generation == 64'd0
      && rsp_found_wid == 8'd0 && !rsp_tomb_evicted)
    else $error("failed command returned data");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ok |-> rsp_found_wid == 8'd0)
    else $error("worker id without success");

  assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response right after reset");

endmodule

bind flow_registry_with_tombstone_ring frt_checker u_frt_checker (
  .clk                  (clk),
  .rst                  (rst),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_ok               (rsp.ok),
  .rsp_status           (rsp.status),
  .rsp_found_generation (rsp.found_generation),
  .rsp_found_wid        (rsp.found_wid),
  .rsp_tomb_evicted     (rsp.tomb_evicted)
);

`default_nettype wire

// ----- test/flow_registry_with_tombstone_ring_test.sv -----
// ----------------------------------------------------------------------------
// flow_registry_with_tombstone_ring_test
// drives flow commands with random handshake gaps, predicts each response
// from a behavioral table and tombstone ring, and checks every response beat
// ----------------------------------------------------------------------------
`default_nettype none

module flow_registry_with_tombstone_ring_test;
  import frt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NENT = TABLE_ENTRIES_DEF;
  localparam int NTOMB = TOMBSTONES_DEF;

  typedef struct packed {
    logic        ok;
    status_t     status;
    logic [63:0] found_generation;
    logic [7:0]  found_wid;
    logic        tomb_evicted;
  } flow_answer_t;

  class flow_scoreboard;
    logic [63:0] ent_key [NENT];
    logic [63:0] ent_gen [NENT];
    logic [63:0] ent_exp [NENT];
    bit          ent_valid [NENT];
    bit          ent_det [NENT];
    bit          ent_drain [NENT];
    logic [7:0]  ent_wid [NENT];
    logic [63:0] tomb_key [NTOMB];
    logic [63:0] tomb_gen [NTOMB];
    logic [63:0] tomb_exp [NTOMB];
    int          rec_head;
    int          rec_count;
    logic [63:0] gen_counter;
    logic [31:0] grace;
    flow_answer_t pending_answers[$];
    int errors;
    int checked;
    int evictions;

    function new();
      for (int i = 0; i < NENT; i++) ent_valid[i] = 0;
      rec_head = 0;
      rec_count = 0;
      gen_counter = 0;
      grace = GRACE_RESET;
      errors = 0;
      checked = 0;
      evictions = 0;
    endfunction

    function int find_flow(logic [63:0] key);
      for (int i = 0; i < NENT; i++)
        if (ent_valid[i] && ent_key[i] == key) return i;
      return -1;
    endfunction

    function void pop_tomb();
      int i;
      i = find_flow(tomb_key[rec_head]);
      if (i >= 0 && ent_det[i] && ent_gen[i] == tomb_gen[rec_head]) ent_valid[i] = 0;
      rec_head = (rec_head + 1) % NTOMB;
      rec_count--;
    endfunction

    function void drain_tombs(logic [63:0] now);
      while (rec_count > 0 && now >= tomb_exp[rec_head]) pop_tomb();
    endfunction

    function bit push_tomb(logic [63:0] key, logic [63:0] gen, logic [63:0] ex,
                           logic [63:0] now);
      bit ev;
      int slot;
      ev = 0;
      drain_tombs(now);
      if (rec_count >= NTOMB) begin
        pop_tomb();
        ev = 1;
      end
      slot = (rec_head + rec_count) % NTOMB;
      tomb_key[slot] = key;
      tomb_gen[slot] = gen;
      tomb_exp[slot] = ex;
      rec_count++;
      return ev;
    endfunction

    function bit routable(int i, logic [63:0] now);
      return !ent_det[i] || now < ent_exp[i];
    endfunction

    // predicts the response of one accepted request beat
    function void note_request(cmd_t cmd, logic [63:0] key, logic [63:0] gen,
                               logic [7:0] wid, logic [7:0] proto, bit graceful,
                               logic [63:0] now);
      flow_answer_t a;
      logic [63:0] ex;
      int i;
      a = '0;
      a.status = ST_DONE;
      ex = now + 64'(grace);
      i = find_flow(key);
      case (cmd)
        CMD_REGISTER: begin
          drain_tombs(now);
          gen_counter++;
          if (gen_counter == 0) gen_counter = 1;
          i = find_flow(key);
          if (i >= 0 && !ent_det[i]) a.status = ST_REFUSED;
          else begin
            if (i < 0) begin
              for (int j = 0; j < NENT; j++)
                if (!ent_valid[j]) begin
                  i = j;
                  break;
                end
            end
            if (i < 0) a.status = ST_FULL;
            else begin
              ent_key[i] = key;
              ent_gen[i] = gen_counter;
              ent_exp[i] = 0;
              ent_valid[i] = 1;
              ent_det[i] = 0;
              ent_drain[i] = 0;
              ent_wid[i] = wid;
              a.ok = 1;
              a.found_generation = gen_counter;
            end
          end
        end
        CMD_UNREGISTER, CMD_RETIRE, CMD_MARK_DRAINING: begin
          if (i < 0 || ent_gen[i] != gen) a.status = ST_NOMATCH;
          else if (cmd == CMD_MARK_DRAINING) ent_drain[i] = 1;
          else if (cmd == CMD_UNREGISTER || !graceful) ent_valid[i] = 0;
          else begin
            ent_det[i] = 1;
            ent_exp[i] = ex;
            a.tomb_evicted = push_tomb(key, gen, ex, now);
          end
        end
        CMD_RETIRE_DRAIN: begin
          if (i < 0 || ent_gen[i] != gen || !ent_drain[i]) a.status = ST_NOMATCH;
          else begin
            ent_drain[i] = 0;
            if (graceful) begin
              ent_det[i] = 1;
              ent_exp[i] = ex;
              a.tomb_evicted = push_tomb(key, gen, ex, now);
            end else ent_valid[i] = 0;
          end
        end
        CMD_LOOKUP: begin
          if (i < 0 || !routable(i, now)) a.status = ST_NOMATCH;
          else begin
            a.ok = 1;
            a.found_generation = ent_gen[i];
            a.found_wid = ent_wid[i];
          end
        end
        CMD_STILL_OWNS: begin
          if (i >= 0 && routable(i, now) && ent_gen[i] == gen && ent_wid[i] == wid) a.ok = 1;
          else a.status = ST_NOMATCH;
        end
        default: begin
          for (int k = 0; k < NENT; k++) ent_valid[k] = 0;
          rec_head = 0;
          rec_count = 0;
        end
      endcase
      if (a.tomb_evicted) evictions++;
      pending_answers.push_back(a);
    endfunction

    function void check_response(flow_answer_t got);
      flow_answer_t e;
      if (pending_answers.size() == 0) begin
        $error("response beat with no request pending");
        errors++;
        return;
      end
      e = pending_answers.pop_front();
      checked++;
      if (got.ok !== e.ok) begin
        $error("ok exp %0d got %0d", e.ok, got.ok);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status);
        errors++;
      end
      if (got.found_generation !== e.found_generation) begin
        $error("found_generation exp %0h got %0h", e.found_generation, got.found_generation);
        errors++;
      end
      if (got.found_wid !== e.found_wid) begin
        $error("found_wid exp %0h got %0h", e.found_wid, got.found_wid);
        errors++;
      end
      if (got.tomb_evicted !== e.tomb_evicted) begin
        $error("tomb_evicted exp %0d got %0d", e.tomb_evicted, got.tomb_evicted);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  always #2 clk = ~clk;

  frt_req_if req();
  frt_rsp_if rsp();
  frt_cfg_if cfg();

  flow_registry_with_tombstone_ring dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  flow_scoreboard flows = new();
  bit quiet_tail = 0;
  bit sink_hold = 0;
  int sent = 0;
  logic [63:0] clock_ms = 64'd1000;
  logic [63:0] known_gen[$];
  logic [63:0] key_pool[16];

  initial begin
    req.valid = 0;
    req.command = CMD_LOOKUP;
    req.tuple_key = 0;
    req.generation = 0;
    req.worker_id = 0;
    req.protocol = 0;
    req.graceful = 0;
    req.now_ms = 0;
    rsp.ready = 0;
    cfg.valid = 0;
    cfg.grace_ms = 0;
  end

  // response side: random stall bursts, sampled at the rising edge
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (sink_hold) begin
        rsp.ready <= 0;
        @(negedge clk);
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        rsp.ready <= 0;
        repeat (gap) @(negedge clk);
      end else begin
        rsp.ready <= 1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk)
    if (!rst && rsp.valid && rsp.ready)
      flows.check_response({rsp.ok, status_t'(rsp.status), rsp.found_generation,
                            rsp.found_wid, rsp.tomb_evicted});

  // valid stays up after the beat; the next call or the caller takes it down
  task automatic send_beat(cmd_t cmd, logic [63:0] key, logic [63:0] gen, logic [7:0] wid,
                           logic [7:0] proto, bit graceful, logic [63:0] now);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req.valid <= 1;
    req.command <= cmd;
    req.tuple_key <= key;
    req.generation <= gen;
    req.worker_id <= wid;
    req.protocol <= proto;
    req.graceful <= graceful;
    req.now_ms <= now;
    do @(posedge clk); while (!req.ready);
    flows.note_request(cmd, key, gen, wid, proto, graceful, now);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_grace(logic [31:0] value);
    req.valid <= 0;
    while (flows.pending_answers.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg.valid <= 1;
    cfg.grace_ms <= value;
    do @(posedge clk); while (!cfg.ready);
    flows.grace = value;
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly well formed flow lifecycles on a small key pool
  task automatic random_item();
    cmd_t cmd;
    logic [63:0] key, gen;
    int r;
    key = key_pool[$urandom_range(0, 15)];
    if ($urandom_range(0, 9) == 0) key = rand64();
    gen = known_gen.size() ? known_gen[$urandom_range(0, known_gen.size() - 1)] : 0;
    r = $urandom_range(0, 99);
    if (r < 8) gen = rand64();
    cmd = cmd_t'($urandom_range(0, 6));
    if ($urandom_range(0, 149) == 0) cmd = CMD_DROP_ALL;
    clock_ms += $urandom_range(0, 3) == 0 ? 64'($urandom_range(0, 20000))
                                           : 64'($urandom_range(0, 50));
    send_beat(cmd, key, gen, 8'($urandom_range(0, 3)), 8'($urandom()), $urandom_range(0, 3) != 0,
              clock_ms);
    if (flows.pending_answers.size() && cmd == CMD_REGISTER)
      known_gen.push_back(flows.gen_counter);
    if (known_gen.size() > 32) void'(known_gen.pop_front());
  endtask

  initial begin
    logic [63:0] g;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    for (int k = 0; k < 16; k++) key_pool[k] = rand64();
    key_pool[0] = 0;
    key_pool[1] = '1;

    // directed: lifecycle of one flow and its special cases
    send_beat(CMD_LOOKUP, 0, 0, 0, 0, 0, 0);
    send_beat(CMD_REGISTER, 0, 0, 8'hff, 8'hff, 1, 0);
    send_beat(CMD_REGISTER, 0, 0, 1, 6, 0, 0);
    send_beat(CMD_LOOKUP, 0, 0, 0, 0, 0, 5);
    send_beat(CMD_STILL_OWNS, 0, 1, 8'hff, 0, 0, 5);
    send_beat(CMD_STILL_OWNS, 0, 1, 8'h00, 0, 0, 5);
    send_beat(CMD_STILL_OWNS, 0, 0, 8'hff, 0, 0, 5);
    send_beat(CMD_MARK_DRAINING, 0, 1, 0, 0, 0, 5);
    send_beat(CMD_RETIRE_DRAIN, 0, 9, 0, 0, 1, 5);
    send_beat(CMD_RETIRE_DRAIN, 0, 1, 0, 0, 1, 5);
    send_beat(CMD_LOOKUP, 0, 0, 0, 0, 0, 10004);
    send_beat(CMD_LOOKUP, 0, 0, 0, 0, 0, 10005);
    send_beat(CMD_REGISTER, 0, 0, 2, 17, 0, 6);
    send_beat(CMD_REGISTER, '1, 0, 3, 0, 0, '1);
    send_beat(CMD_RETIRE, '1, 4, 0, 0, 0, '1);
    send_beat(CMD_UNREGISTER, 0, 3, 0, 0, 0, 7);
    send_beat(CMD_RETIRE, 0, 3, 0, 0, 0, 7);
    send_beat(CMD_REGISTER, 64'h55, 0, 0, 0, 0, 7);
    send_beat(CMD_MARK_DRAINING, 64'h55, 5, 0, 0, 0, 7);
    send_beat(CMD_RETIRE_DRAIN, 64'h55, 5, 0, 0, 0, 7);
    send_beat(CMD_DROP_ALL, 0, 0, 0, 0, 0, 8);

    // fill the table to overflow, then a ring wrap with evictions
    write_grace(32'hffffffff);
    for (int k = 0; k < NENT + 1; k++)
      send_beat(CMD_REGISTER, 64'(k + 100), 0, 8'(k), 8'(k), 0, 100);
    for (int k = 0; k < 70; k++) begin
      g = flows.ent_gen[k];
      send_beat(CMD_RETIRE, 64'(k + 100), g, 0, 0, 1, 64'(200 + k));
    end
    // stall the response side so the request side backs up
    sink_hold = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        sink_hold = 0;
      end
      for (int k = 0; k < 6; k++)
        send_beat(CMD_LOOKUP, 64'(k + 100), 0, 0, 0, 0, 300);
    join
    send_beat(CMD_DROP_ALL, 0, 0, 0, 0, 0, 400);

    write_grace(32'd0);
    for (int k = 0; k < 100; k++) random_item();
    write_grace(32'd3000);
    for (int k = 0; k < 120; k++) random_item();
    write_grace(32'd200000);
    for (int k = 0; k < 80; k++) random_item();
    quiet_tail = 1;
    for (int k = 0; k < 40; k++) random_item();
    req.valid <= 0;

    while (flows.pending_answers.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("sent %0d requests, checked %0d responses, %0d tombstone evictions",
             sent, flows.checked, flows.evictions);
    if (flows.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/frt_pkg.sv
hdl/frt_ifs.sv
hdl/flow_registry_with_tombstone_ring.sv
hdl/frt_checker.sv
test/flow_registry_with_tombstone_ring_test.sv
